// ----- rtl/core/dfq_pkg.sv -----
// Package for the deduplicating FIFO queue: sizes, operation and status codes,
// the request and response beat types and the controller types.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package dfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_FIND    = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_RANGE    = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    typedef struct packed {
        op_t                   operation;
        logic [DATA_WIDTH-1:0] item_value;
        logic [IDX_W-1:0]      read_index;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [DATA_WIDTH-1:0] data_out;
        logic [IDX_W-1:0]      found_index;
        logic [COUNT_W-1:0]    entry_count;
    } rsp_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } dfq_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/dfq_ctrl.sv -----
// Controller of the deduplicating FIFO queue: a two-state machine that takes
// a request beat, then executes it once the response register is free.
// Depends on dfq_pkg.
`default_nettype none

module dfq_ctrl
    import dfq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output dfq_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        rsp_free;

    // The response register can take a new beat when empty or being drained.
    assign rsp_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        req_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            S_EXEC:
            begin
                cmd.execute = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dfq_datapath.sv -----
// Datapath of the deduplicating FIFO queue: the shifting entry registers, the
// count, the per-entry comparators, the request and the response registers.
// Depends on dfq_pkg.
`default_nettype none

module dfq_datapath
    import dfq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dfq_cmd_t cmd,
    input  wire req_t     req,
    output rsp_t          rsp
);

    logic [DATA_WIDTH-1:0] entries_reg [QUEUE_DEPTH];
    logic [COUNT_W-1:0]    count_reg, count_next;
    req_t                  req_reg;
    rsp_t                  rsp_reg, rsp_next;

    logic [QUEUE_DEPTH-1:0] match_vec;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic                   is_full;
    logic                   is_empty;
    logic                   do_enq;
    logic                   do_deq;

    // Every held entry is compared at once; unheld positions are masked off.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match_vec[i] = (COUNT_W'(i) < count_reg) &&
                           (entries_reg[i] == req_reg.item_value);
        end
    end

    // Lowest matching position wins.
    always_comb
    begin
        hit_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit      = |match_vec;
    assign is_full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.status      = ST_OK;
        count_next           = count_reg;
        do_enq               = 1'b0;
        do_deq               = 1'b0;
        case (req_reg.operation)
            OP_ENQUEUE:
            begin
                if (is_full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else if (hit)
                begin
                    rsp_next.status = ST_DUP;
                end
                else
                begin
                    do_enq     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEQUEUE:
            begin
                if (is_empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    do_deq            = 1'b1;
                    rsp_next.data_out = entries_reg[0];
                    count_next        = count_reg - 1'b1;
                end
            end
            OP_FIND:
            begin
                if (hit)
                begin
                    rsp_next.found_index = hit_idx;
                end
                else
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
            end
            OP_READ:
            begin
                if (COUNT_W'(req_reg.read_index) < count_reg)
                begin
                    rsp_next.data_out = entries_reg[req_reg.read_index];
                end
                else
                begin
                    rsp_next.status = ST_RANGE;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
        rsp_next.entry_count = count_next;
    end

    // Entries hold no reset value; only positions below the count are read.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
            if (do_deq)
            begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                begin
                    entries_reg[i] <= entries_reg[i + 1];
                end
            end
            else if (do_enq)
            begin
                entries_reg[count_reg[IDX_W-1:0]] <= req_reg.item_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dedup_fifo_queue.sv -----
// Top level of the deduplicating FIFO queue: joins the controller and the
// datapath. Depends on dfq_pkg, dfq_ctrl and dfq_datapath.
//
// Usage: each request beat on req carries one operation: enqueue a value,
// dequeue the oldest value, find the position of a value, or read the value
// at a position (0 is the oldest). The queue never holds the same value
// twice; an enqueue of a held value reports a duplicate status, and an
// enqueue into a full queue reports full. Every response beat on rsp carries
// a status, the dequeued or read data, the found position and the number of
// entries held after the operation.
// Both channels use valid and stall; a beat moves at a clock edge with valid
// high and stall low.
// Order: an accepted request beat is first registered, then compared against
// all entries in parallel; the queue is updated at an edge at which the
// response register is free, and the response is valid right after that
// edge. A new request is taken only once the previous one has executed.
// The response sits in its own register, so a request can be taken while the
// previous response still waits. When the receiver stalls, the response is
// held, and the next request waits in execution until the response moves.
// Reset clears the count and all handshake state; the queue starts empty.
`default_nettype none

module dedup_fifo_queue
    import dfq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    dfq_cmd_t cmd;

    dfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    dfq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ----- dv/dfq_tb_pkg.sv -----
// Scoreboard for the deduplicating FIFO queue testbench: keeps its own copy of the
// held values, predicts one response beat per request beat and checks arrivals.
// Depends on dfq_pkg for the beat types and the operation and status codes.
package dfq_tb_pkg;

    import dfq_pkg::*;

    class queue_tracker;

        logic [DATA_WIDTH-1:0] held_values[$];
        rsp_t                  pending_responses[$];
        int                    mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Lowest position that holds the value, or -1 when it is not held.
        function int position_of(logic [DATA_WIDTH-1:0] value);
            for (int i = 0; i < held_values.size(); i++)
            begin
                if (held_values[i] == value)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Applies an accepted request to the held values and queues its response.
        function void note_request(req_t r);
            rsp_t want;
            int   pos;
            want        = '0;
            want.status = ST_OK;
            case (r.operation)
                OP_ENQUEUE:
                begin
                    // A full queue reports full even for a value it already holds.
                    if (held_values.size() >= QUEUE_DEPTH)
                    begin
                        want.status = ST_FULL;
                    end
                    else if (position_of(r.item_value) >= 0)
                    begin
                        want.status = ST_DUP;
                    end
                    else
                    begin
                        held_values.push_back(r.item_value);
                    end
                end
                OP_DEQUEUE:
                begin
                    if (held_values.size() == 0)
                    begin
                        want.status = ST_EMPTY;
                    end
                    else
                    begin
                        want.data_out = held_values.pop_front();
                    end
                end
                OP_FIND:
                begin
                    pos = position_of(r.item_value);
                    if (pos >= 0)
                    begin
                        want.found_index = IDX_W'(pos);
                    end
                    else
                    begin
                        want.status = ST_NOTFOUND;
                    end
                end
                default:
                begin
                    if (int'(r.read_index) < held_values.size())
                    begin
                        want.data_out = held_values[r.read_index];
                    end
                    else
                    begin
                        want.status = ST_RANGE;
                    end
                end
            endcase
            want.entry_count = COUNT_W'(held_values.size());
            pending_responses.push_back(want);
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("ERROR at %0t: %s", $time, what);
        endtask

        // Compares one response beat with the oldest predicted response.
        task check_response(rsp_t got);
            rsp_t want;
            if (pending_responses.size() == 0)
            begin
                report_mismatch("response beat with no request outstanding");
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status)
            begin
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            end
            if (got.data_out !== want.data_out)
            begin
                report_mismatch($sformatf("data_out %h, expected %h",
                                          got.data_out, want.data_out));
            end
            if (got.found_index !== want.found_index)
            begin
                report_mismatch($sformatf("found_index %0d, expected %0d",
                                          got.found_index, want.found_index));
            end
            if (got.entry_count !== want.entry_count)
            begin
                report_mismatch($sformatf("entry_count %0d, expected %0d",
                                          got.entry_count, want.entry_count));
            end
        endtask

    endclass

endpackage

// ----- dv/tb.sv -----
// Top of the testbench for dedup_fifo_queue: drives request beats, takes response
// beats under random stalls and checks each against the scoreboard's prediction.
// Depends on dfq_pkg, dfq_tb_pkg and the RTL under rtl/core.
module tb;

    import dfq_pkg::*;
    import dfq_tb_pkg::*;

    // Generous bound on the whole run, in cycles.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 700;
    localparam int LONG_HOLD      = 120;

    // Which operation mix the random part leans toward, so that the queue
    // count wanders over its whole range, from empty to full and back.
    typedef enum int {
        LEAN_FILL,
        LEAN_DRAIN,
        LEAN_MIX
    } lean_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    queue_tracker tracker;

    // hold_off_request and receiver_holding are shared between the sender and the receiver process.
    bit sender_burst;
    bit receiver_burst;
    bit hold_off_request;
    bit receiver_holding;
    int timeout_cycles;

    dedup_fifo_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic req_t make_req(op_t op, logic [DATA_WIDTH-1:0] value,
                                      logic [IDX_W-1:0] idx);
        req_t r;
        r.operation  = op;
        r.item_value = value;
        r.read_index = idx;
        return r;
    endfunction

    // Builds one random request from the current queue contents. Enqueues
    // often reuse a held value or a value from a small pool so that duplicates
    // come up; finds mostly look for held values; reads mostly land in range.
    // The fields that an operation ignores still carry random bits.
    function automatic req_t random_request(lean_t lean);
        int                    roll;
        int                    enq_cut;
        int                    deq_cut;
        int                    held;
        op_t                   op;
        logic [DATA_WIDTH-1:0] value;
        logic [IDX_W-1:0]      idx;
        held = tracker.held_values.size();
        case (lean)
            LEAN_FILL:
            begin
                enq_cut = 55;
                deq_cut = 68;
            end
            LEAN_DRAIN:
            begin
                enq_cut = 20;
                deq_cut = 62;
            end
            default:
            begin
                enq_cut = 35;
                deq_cut = 62;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < enq_cut)
            op = OP_ENQUEUE;
        else if (roll < deq_cut)
            op = OP_DEQUEUE;
        else if (roll < deq_cut + (100 - deq_cut) / 2)
            op = OP_FIND;
        else
            op = OP_READ;
        value = $urandom;
        idx   = IDX_W'($urandom_range(0, QUEUE_DEPTH - 1));
        roll  = $urandom_range(0, 9);
        if (op == OP_ENQUEUE || op == OP_FIND)
        begin
            if (held > 0 && roll < (op == OP_FIND ? 6 : 2))
                value = tracker.held_values[$urandom_range(0, held - 1)];
            else if (roll < 6)
                value = $urandom_range(0, 23);
        end
        else if (op == OP_READ && held > 0 && roll < 7)
        begin
            idx = IDX_W'($urandom_range(0, held - 1));
        end
        return make_req(op, value, idx);
    endfunction

    // Offers one request beat after a random gap and returns at the edge that
    // accepts it, leaving valid high so that a following beat can go out back
    // to back. The payload stays put while the block stalls.
    task automatic send_request(input req_t r);
        int gap;
        gap = (sender_burst || receiver_holding) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        tracker.note_request(r);
    endtask

    // Stops offering and waits until every predicted response has arrived.
    // Always waits on the clock before checking, so valid is never lowered and
    // raised again at the same edge.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Stimulus: a directed part that walks the queue through its corner cases,
    // then random requests with phases of back-to-back beats, one long
    // receiver hold-off that fills the block and stalls its input, and one
    // pause in which the sender waits until everything has come back.
    initial
    begin
        int    n;
        lean_t lean;
        tracker          = new();
        sender_burst     = 1'b0;
        receiver_burst   = 1'b0;
        hold_off_request = 1'b0;
        receiver_holding = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_stall <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: dequeue reports empty, read is out of range, find misses.
        send_request(make_req(OP_DEQUEUE, 32'h0000_0000, 4'd0));
        send_request(make_req(OP_READ, 32'hFFFF_FFFF, 4'd0));
        send_request(make_req(OP_FIND, 32'h0000_0000, 4'd0));
        // The extreme values, then a duplicate of the first one.
        send_request(make_req(OP_ENQUEUE, 32'h0000_0000, 4'hF));
        send_request(make_req(OP_ENQUEUE, 32'hFFFF_FFFF, 4'h0));
        send_request(make_req(OP_ENQUEUE, 32'h0000_0000, 4'h0));
        send_request(make_req(OP_FIND, 32'hFFFF_FFFF, 4'h0));
        send_request(make_req(OP_FIND, 32'h5A5A_A5A5, 4'hF));
        send_request(make_req(OP_READ, 32'h0000_0000, 4'd1));
        // A read exactly at the count is out of range.
        send_request(make_req(OP_READ, 32'h0000_0000, 4'd2));
        for (n = 0; n < QUEUE_DEPTH - 2; n++)
        begin
            send_request(make_req(OP_ENQUEUE, 32'h1000_0000 + n, IDX_W'(n)));
        end
        // Full queue: full wins over duplicate, and a new value is dropped.
        send_request(make_req(OP_ENQUEUE, 32'hFFFF_FFFF, 4'd0));
        send_request(make_req(OP_ENQUEUE, 32'h1234_5678, 4'd0));
        // The last position is readable and searchable when full.
        send_request(make_req(OP_READ, 32'h0000_0000, 4'd15));
        send_request(make_req(OP_FIND, 32'h1000_000D, 4'd0));
        // Dequeue shifts everything down, so position 15 is now out of range.
        send_request(make_req(OP_DEQUEUE, 32'hFFFF_FFFF, 4'hF));
        send_request(make_req(OP_READ, 32'h0000_0000, 4'd15));
        drain_responses();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
                sender_burst = ($urandom_range(0, 2) == 0);
            if (n == 250)
            begin
                // The receiver counts the hold-off itself; the sender keeps
                // offering beats back to back until the hold is over.
                receiver_holding = 1'b1;
                hold_off_request = 1'b1;
            end
            if (n == 450)
                drain_responses();
            lean = lean_t'((n / 40) % 3);
            send_request(random_request(lean));
        end
        drain_responses();
        // Keep the clock running to catch any response beat nobody asked for.
        repeat (8) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Receiver: checks every accepted response beat and then stalls for a
    // random number of cycles, with stretches of no stalling at all. On
    // request it holds off for a long stretch so the block backs up.
    initial
    begin
        int hold_left;
        int long_hold_left;
        int beats;
        hold_left      = 0;
        long_hold_left = 0;
        beats          = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                tracker.check_response(rsp);
                beats++;
                if (beats % 50 == 0)
                    receiver_burst = !receiver_burst;
                hold_left = receiver_burst ? 0 : $urandom_range(0, 11);
            end
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                long_hold_left   = LONG_HOLD;
            end
            if (long_hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                long_hold_left--;
                if (long_hold_left == 0)
                    receiver_holding = 1'b0;
            end
            else if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++)
        begin
            @(posedge clk);
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dfq_pkg.sv
rtl/core/dfq_ctrl.sv
rtl/core/dfq_datapath.sv
rtl/core/dedup_fifo_queue.sv
dv/dfq_tb_pkg.sv
dv/tb.sv
